FILE: hw/rtl/command_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// Command frame decoder: assertion macros
// Shared property wrappers for the port checker, sampled on clk, held off
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_DECODER_DEFINES_SVH
`define COMMAND_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication.
`define CFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("command_frame_decoder: same-cycle check failed");

// Next-cycle implication.
`define CFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("command_frame_decoder: next-cycle check failed");

`endif

FILE: hw/rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// Command frame decoder package
// Codes, constants and the decoded-frame record shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

    localparam int unsigned FRAME_LEN = 13;
    localparam int unsigned CNT_W     = 4;

    // Input command codes
    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_LIMIT1 = 2'd1;
    localparam logic [1:0] CMD_LIMIT2 = 2'd2;

    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] TRL_BYTE   = 8'hEF;
    localparam logic [7:0] OPT_ON     = 8'h11;
    localparam logic [7:0] DIR_REV    = 8'h10;
    localparam logic [7:0] MID_LIMIT1 = 8'h0F;
    localparam logic [7:0] MID_LIMIT2 = 8'hF0;
    localparam logic [7:0] STAT_EDGE  = 8'hFF;

    localparam logic [7:0] RATE_RST   = 8'd230;
    localparam logic [7:0] DUTY_RST   = 8'd255;

    localparam int unsigned TDATA_W   = 48;

    typedef struct packed {
        logic       ok;        // complete frame with good header and trailer
        logic       adc;
        logic       led;
        logic       en;
        logic       dir_set;
        logic       dir_val;
        logic [7:0] rate;
        logic [7:0] duty;
        logic [7:0] dac_high;
        logic [7:0] dac_low;
    } frame_dec_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cfd_frame.sv
// ----------------------------------------------------------------------------
// Command frame decoder: frame assembly
// Stores received bytes, tracks the byte position and decodes a full frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_frame (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     wr_en,
    input  wire  [7:0]              rx_byte,
    output cfd_pkg::frame_dec_t     dec
);

    logic [7:0]                store_reg [cfd_pkg::FRAME_LEN];
    logic [cfd_pkg::CNT_W-1:0] count_reg;
    logic [cfd_pkg::CNT_W-1:0] count_next;
    logic [cfd_pkg::CNT_W-1:0] idx;
    logic [cfd_pkg::CNT_W-1:0] idx_inc;
    logic [7:0]                first_byte;
    logic                      frame_end;

    always_comb
    begin
        idx = (count_reg >= cfd_pkg::CNT_W'(cfd_pkg::FRAME_LEN)) ? '0 : count_reg;
        // byte 0 may be the one arriving now
        first_byte = (idx == '0) ? rx_byte : store_reg[0];
        idx_inc    = (first_byte == cfd_pkg::HDR_BYTE) ? idx + 1'b1 : '0;
        frame_end  = (idx_inc == cfd_pkg::CNT_W'(cfd_pkg::FRAME_LEN));
        count_next = frame_end ? '0 : idx_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (wr_en)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[idx] <= rx_byte;
        end
    end

    // The closing byte is the one arriving now; all others are stored.
    always_comb
    begin
        dec.ok       = frame_end
                       && (store_reg[1] == cfd_pkg::HDR_BYTE)
                       && (store_reg[11] == cfd_pkg::TRL_BYTE)
                       && (rx_byte == cfd_pkg::TRL_BYTE);
        dec.adc      = (store_reg[2] == cfd_pkg::OPT_ON);
        dec.led      = (store_reg[3] == cfd_pkg::OPT_ON);
        dec.en       = (store_reg[4] == cfd_pkg::OPT_ON);
        dec.dir_set  = (store_reg[5] == cfd_pkg::OPT_ON) || (store_reg[5] == cfd_pkg::DIR_REV);
        dec.dir_val  = (store_reg[5] == cfd_pkg::DIR_REV);
        dec.rate     = store_reg[6];
        dec.duty     = store_reg[7];
        dec.dac_high = store_reg[9];
        dec.dac_low  = store_reg[10];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cfd_ctrl.sv
// ----------------------------------------------------------------------------
// Command frame decoder: control levels and result register
// Applies decoded frames and limit events to the drive levels and holds the
// result, stepping through the four bytes of a status message.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_ctrl (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           advance,
    input  wire  [1:0]                    command,
    input  wire  cfd_pkg::frame_dec_t     dec,
    output logic                          out_free,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [cfd_pkg::TDATA_W-1:0]   m_tdata,  // led_on, motor_enable, motor_direction,
                                                    // step_rate_reload[7:0], pwm_duty[7:0],
                                                    // dac_write, dac_high[7:0], dac_low[7:0],
                                                    // adc_request, tx_byte[7:0], zero pad
    output logic                          m_tuser,  // tx_valid
    output logic                          m_tlast
);

    logic       led_reg, led_next;
    logic       en_reg, en_next;
    logic       dir_reg, dir_next;
    logic [7:0] rate_reg, rate_next;
    logic [7:0] duty_reg, duty_next;

    logic       out_valid_reg;
    logic       dac_w_reg, dac_w_next;
    logic [7:0] dac_high_reg, dac_high_next;
    logic [7:0] dac_low_reg, dac_low_next;
    logic       adc_reg, adc_next;
    logic       tx_reg, tx_next;
    logic [7:0] mid_reg, mid_next;
    logic [1:0] beat_reg;

    logic       is_last;
    logic [7:0] tx_byte;
    logic       good_frame;

    assign is_last  = !tx_reg || (beat_reg == 2'd3);
    assign out_free = !out_valid_reg || (m_tready && is_last);
    assign good_frame = (command == cfd_pkg::CMD_BYTE) && dec.ok;

    always_comb
    begin
        led_next      = led_reg;
        en_next       = en_reg;
        dir_next      = dir_reg;
        rate_next     = rate_reg;
        duty_next     = duty_reg;
        dac_w_next    = 1'b0;
        dac_high_next = '0;
        dac_low_next  = '0;
        adc_next      = 1'b0;
        tx_next       = 1'b0;
        mid_next      = cfd_pkg::MID_LIMIT1;
        case (command)
            cfd_pkg::CMD_LIMIT1:
            begin
                if (!dir_reg)
                begin
                    en_next  = 1'b0;
                    dir_next = 1'b1;
                    tx_next  = 1'b1;
                    mid_next = cfd_pkg::MID_LIMIT1;
                end
            end
            cfd_pkg::CMD_LIMIT2:
            begin
                if (dir_reg)
                begin
                    en_next  = 1'b0;
                    dir_next = 1'b0;
                    tx_next  = 1'b1;
                    mid_next = cfd_pkg::MID_LIMIT2;
                end
            end
            default:
            begin
                if (good_frame)
                begin
                    adc_next   = dec.adc;
                    led_next   = dec.led;
                    dac_w_next = dec.led;
                    if (dec.led)
                    begin
                        dac_high_next = dec.dac_high;
                        dac_low_next  = dec.dac_low;
                    end
                    en_next = dec.en;
                    if (dec.en && dec.dir_set)
                    begin
                        dir_next = dec.dir_val;
                    end
                    rate_next = dec.rate;
                    duty_next = dec.duty;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg       <= 1'b0;
            en_reg        <= 1'b0;
            dir_reg       <= 1'b0;
            rate_reg      <= cfd_pkg::RATE_RST;
            duty_reg      <= cfd_pkg::DUTY_RST;
            out_valid_reg <= 1'b0;
            tx_reg        <= 1'b0;
            beat_reg      <= '0;
        end
        else if (advance)
        begin
            led_reg       <= led_next;
            en_reg        <= en_next;
            dir_reg       <= dir_next;
            rate_reg      <= rate_next;
            duty_reg      <= duty_next;
            out_valid_reg <= 1'b1;
            tx_reg        <= tx_next;
            beat_reg      <= '0;
        end
        else if (out_valid_reg && m_tready)
        begin
            // advance the status message, or drop the delivered result
            if (is_last)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                beat_reg <= beat_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dac_w_reg    <= dac_w_next;
            dac_high_reg <= dac_high_next;
            dac_low_reg  <= dac_low_next;
            adc_reg      <= adc_next;
            mid_reg      <= mid_next;
        end
    end

    always_comb
    begin
        if (!tx_reg)
        begin
            tx_byte = '0;
        end
        else if ((beat_reg == 2'd1) || (beat_reg == 2'd2))
        begin
            tx_byte = mid_reg;
        end
        else
        begin
            tx_byte = cfd_pkg::STAT_EDGE;
        end
    end

    // levels only change when the next item enters, so read them directly
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, tx_byte, adc_reg, dac_low_reg, dac_high_reg, dac_w_reg,
                       duty_reg, rate_reg, dir_reg, en_reg, led_reg};
    assign m_tuser  = tx_reg;
    assign m_tlast  = is_last;

endmodule

`default_nettype wire

FILE: hw/rtl/command_frame_decoder.sv
// ----------------------------------------------------------------------------
// Command frame decoder
// Assembles 13-byte command frames and drives LED, DAC, motor and PWM levels;
// limit events stop the motor and send a 4-byte status message.
// ----------------------------------------------------------------------------
// Use:
//   Slave side: one transfer per item; s_tuser is the command (received byte,
//   limit one edge, limit two sample), s_tdata the received byte.
//   Master side: one transfer per result; every result carries the current
//   drive levels; m_tuser flags a status byte, m_tlast ends the item.
//   An accepted item waits in the input register until the result register is
//   free; its first result is then loaded there and offered to the receiver.
//   Throughput is one item per cycle while m_tready is high and each item
//   gives one result; a firing limit event takes four result transfers.
//   While the receiver stalls, the result holds and one more item may be
//   taken into the input register, after which s_tready drops.
//   Reset clears the byte position, the LED, motor and PWM levels (rate 230,
//   duty 255) and both valid flags; frame bytes stay, and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_decoder (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [7:0]                   s_tdata,  // rx_byte[7:0]
    input  wire  [1:0]                   s_tuser,  // command[1:0]
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [cfd_pkg::TDATA_W-1:0]  m_tdata,  // led_on, motor_enable, motor_direction,
                                                   // step_rate_reload[7:0], pwm_duty[7:0],
                                                   // dac_write, dac_high[7:0], dac_low[7:0],
                                                   // adc_request, tx_byte[7:0], zero pad
    output logic                         m_tuser,  // tx_valid
    output logic                         m_tlast
);

    logic                in_valid_reg;
    logic [1:0]          in_cmd_reg;
    logic [7:0]          in_byte_reg;
    logic                out_free;
    logic                advance;
    cfd_pkg::frame_dec_t dec;

    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    cfd_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (advance && (in_cmd_reg == cfd_pkg::CMD_BYTE)),
        .rx_byte (in_byte_reg),
        .dec     (dec)
    );

    cfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .command  (in_cmd_reg),
        .dec      (dec),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/cfd_checker.sv
// ----------------------------------------------------------------------------
// Command frame decoder: port checker
// Watches the result channel of the top level for consistent status messages.
// ----------------------------------------------------------------------------
`default_nettype none

`include "command_frame_decoder_defines.svh"

module cfd_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [cfd_pkg::TDATA_W-1:0]   m_tdata,
    input wire                          m_tuser,
    input wire                          m_tlast
);

    // a stalled result stays offered
    `CFD_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

    // a status message continues with another status byte
    `CFD_ASSERT_NEXT(a_status_runs, m_tvalid && m_tready && m_tuser && !m_tlast, m_tvalid && m_tuser)

    // status bytes carry no DAC write and no ADC request
    `CFD_ASSERT_NOW(a_status_quiet, m_tvalid && m_tuser, !m_tdata[19] && !m_tdata[36])

    // a limit event always leaves the motor off
    `CFD_ASSERT_NOW(a_status_motor_off, m_tvalid && m_tuser, !m_tdata[1])

    // ordinary items give a single result
    `CFD_ASSERT_NOW(a_plain_single, m_tvalid && !m_tuser, m_tlast)

endmodule

bind command_frame_decoder cfd_checker u_cfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
